@@ rtl/acrms_pkg.sv @@
// Shared types, widths and codes for the AC current RMS meter.
// No dependencies; imported by every module of the block.
package acrms_pkg;

  localparam int ADC_WIDTH = 12;
  localparam int FILT_W    = 24;   // filtered sample, signed Q15.8
  localparam int T_W       = ((ADC_WIDTH + 9 > FILT_W) ? ADC_WIDTH + 9 : FILT_W) + 1;
  localparam int MUL_A_W   = 33;
  localparam int MUL_P_W   = MUL_A_W + T_W;
  localparam int SUM_W     = 64;
  localparam int DIVR_W    = 16;
  localparam int ROOT_W    = SUM_W / 2;
  localparam int VOLTS_W   = 9;

  // current times volts plus rounding
  localparam int PWR_W       = 25;
  // divide by 1000: drop three bits, then multiply by ceil(2^29 / 125) and shift by 29
  localparam int POWER_SHIFT = 29;
  localparam logic [MUL_A_W-1:0] POWER_RECIP = MUL_A_W'(4294968);
  localparam logic [PWR_W-1:0]   POWER_RND   = PWR_W'(500);

  typedef enum logic [1:0] {
    CFG_FILTER_COEF = 2'd0,
    CFG_SCALE       = 2'd1,
    CFG_THRESHOLD   = 2'd2,
    CFG_MAINS_VOLTS = 2'd3
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILT,
    ST_YSAT,
    ST_SQ,
    ST_ACC,
    ST_DIV,
    ST_DIV_WAIT,
    ST_SQRT_WAIT,
    ST_SCALE,
    ST_CUR,
    ST_PMUL,
    ST_PDIV,
    ST_PDIV_WAIT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [ADC_WIDTH-1:0] adc_sample;
    logic                 window_start;
    logic                 window_end;
  } sample_t;

  typedef struct packed {
    logic [15:0] current_ma;
    logic [15:0] power_w;
    logic [15:0] samples_used;
    logic        below_threshold;
  } result_t;

endpackage

@@ rtl/acrms_mul.sv @@
// Shared signed multiplier with registered product.
// Depends on acrms_pkg for operand widths.
module acrms_mul import acrms_pkg::*; (
  input  logic                      clk,
  input  logic signed [MUL_A_W-1:0] a,
  input  logic signed [T_W-1:0]     b,
  output logic signed [MUL_P_W-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

@@ rtl/acrms_div.sv @@
// Restoring divider, one quotient bit per cycle, 64-bit dividend by 16-bit divisor.
// Depends on acrms_pkg for widths.
module acrms_div import acrms_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SUM_W-1:0]  dividend,
  input  logic [DIVR_W-1:0] divisor,
  output logic [SUM_W-1:0]  quotient,
  output logic              done
);

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic [DIVR_W:0]   rem;
  logic [DIVR_W-1:0] dsor;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic [DIVR_W:0]   shifted;

  assign shifted = {rem[DIVR_W-1:0], quotient[SUM_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= CNT_W'(SUM_W);
        rem      <= '0;
        dsor     <= divisor;
        quotient <= dividend;
      end else if (busy) begin
        if (shifted >= {1'b0, dsor}) begin
          rem      <= shifted - {1'b0, dsor};
          quotient <= {quotient[SUM_W-2:0], 1'b1};
        end else begin
          rem      <= shifted;
          quotient <= {quotient[SUM_W-2:0], 1'b0};
        end
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/acrms_sqrt.sv @@
// Digit-by-digit integer square root, two radicand bits per cycle.
// Depends on acrms_pkg for widths.
module acrms_sqrt import acrms_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SUM_W-1:0]  radicand,
  output logic [ROOT_W-1:0] root,
  output logic              done
);

  localparam int STEPS = SUM_W / 2;
  localparam int CNT_W = $clog2(STEPS + 1);
  localparam int REM_W = ROOT_W + 1;
  localparam int R_W   = ROOT_W + 3;

  logic [SUM_W-1:0] val;
  logic [REM_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [R_W-1:0]   r;
  logic [R_W-1:0]   trial;
  logic [R_W-1:0]   diff;

  assign r     = {rem, val[SUM_W-1 -: 2]};
  assign trial = {1'b0, root, 2'b01};
  assign diff  = r - trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(STEPS);
        val  <= radicand;
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        if (r >= trial) begin
          rem  <= diff[REM_W-1:0];
          root <= {root[ROOT_W-2:0], 1'b1};
        end else begin
          rem  <= r[REM_W-1:0];
          root <= {root[ROOT_W-2:0], 1'b0};
        end
        val <= {val[SUM_W-3:0], 2'b00};
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/ac_current_rms_meter.sv @@
// Top level of the AC current RMS meter: sequencer, state and config registers.
// Depends on acrms_pkg, acrms_mul, acrms_div and acrms_sqrt.
//
//  channel   direction  handshake                  payload
//  sample    in         sample_valid/sample_ready  sample_t
//  result    out        result_valid/result_ready  result_t
//  cfg       in         cfg_valid/cfg_ready        cfg_index, cfg_data
//
// A priming sample without window end is taken in ST_IDLE; a sample without window start goes
// through the shared multiplier (filter product, then square, then accumulate).
// A window end adds a 64-step divider run, a 32-step root and a few multiplier steps
// (an empty window skips the division).
// rst is synchronous and restores config defaults and clears the window state.
// A result waits in the output register; a later window end stalls only when it is still full.
module ac_current_rms_meter import acrms_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        sample_valid,
  output logic        sample_ready,
  input  sample_t     sample,
  output logic        result_valid,
  input  logic        result_ready,
  output result_t     result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  cfg_reg_t    cfg_index,
  input  logic [15:0] cfg_data
);

  localparam logic signed [MUL_P_W-1:0] Y_MAX = MUL_P_W'(2**(FILT_W-1) - 1);
  localparam logic signed [MUL_P_W-1:0] Y_MIN = MUL_P_W'(-(2**(FILT_W-1)));
  localparam logic [MUL_P_W-1:0]        RND16 = MUL_P_W'(32768);

  state_t state, state_next;

  logic [15:0]          filter_coef;
  logic [15:0]          scale;
  logic [15:0]          threshold;
  logic [VOLTS_W-1:0]   mains_volts;

  logic [ADC_WIDTH-1:0] prev_sample;
  logic [FILT_W-1:0]    prev_filtered;
  logic [SUM_W-1:0]     square_sum;
  logic [15:0]          sample_counter;

  logic [ADC_WIDTH-1:0] x_q;
  logic                 end_q;
  logic [15:0]          cur_reg;
  logic                 cut_reg;
  logic [15:0]          pwr_reg;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [T_W-1:0]     mul_b;
  logic signed [MUL_P_W-1:0] prod;

  logic              div_start;
  logic [SUM_W-1:0]  div_dividend;
  logic [DIVR_W-1:0] div_divisor;
  logic [SUM_W-1:0]  div_quo;
  logic              div_done;

  logic              sqrt_start;
  logic [SUM_W-1:0]  sqrt_radicand;
  logic [ROOT_W-1:0] rms;
  logic              sqrt_done;

  logic              result_load;
  logic              accept;

  // filter, accumulate and result datapath
  logic signed [ADC_WIDTH:0]  diff;
  logic signed [T_W-1:0]      t;
  logic signed [MUL_P_W-1:0]  y_round;
  logic signed [MUL_P_W-1:0]  y_shift;
  logic [FILT_W-1:0]          y_sat;
  logic [SUM_W:0]             sum_add;
  logic [MUL_P_W-1:0]         cur_round;
  logic [15:0]                cur_val;
  logic [PWR_W-1:0]           pwr_num;

  assign sample_ready = (state == ST_IDLE);
  assign cfg_ready    = 1'b1;
  assign accept       = sample_valid && sample_ready;

  assign diff = $signed({1'b0, x_q}) - $signed({1'b0, prev_sample});
  assign t    = $signed({{(T_W-FILT_W){prev_filtered[FILT_W-1]}}, prev_filtered})
              + ($signed({{(T_W-ADC_WIDTH-1){diff[ADC_WIDTH]}}, diff}) <<< 8);

  assign y_round = prod + $signed(RND16);
  assign y_shift = y_round >>> 16;

  always_comb begin
    if (y_shift > Y_MAX) begin
      y_sat = Y_MAX[FILT_W-1:0];
    end else if (y_shift < Y_MIN) begin
      y_sat = Y_MIN[FILT_W-1:0];
    end else begin
      y_sat = y_shift[FILT_W-1:0];
    end
  end

  assign sum_add   = {1'b0, square_sum} + (SUM_W+1)'(prod[2*FILT_W-1:0]);
  assign cur_round = prod + RND16;
  assign cur_val   = (cur_round[MUL_P_W-1:32] != '0) ? 16'hFFFF : cur_round[31:16];
  // rounded power numerator, already divided by 8
  assign pwr_num   = (prod[PWR_W-1:0] + POWER_RND) >> 3;

  acrms_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  acrms_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quo),
    .done     (div_done)
  );

  acrms_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (sqrt_radicand),
    .root     (rms),
    .done     (sqrt_done)
  );

  always_comb begin
    state_next    = state;
    mul_a         = '0;
    mul_b         = '0;
    div_start     = 1'b0;
    div_dividend  = square_sum;
    div_divisor   = sample_counter;
    sqrt_start    = 1'b0;
    sqrt_radicand = (sample_counter == '0) ? '0 : div_quo;
    result_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (!sample.window_start) begin
            state_next = ST_FILT;
          end else if (sample.window_end) begin
            state_next = ST_DIV;
          end
        end
      end
      ST_FILT: begin
        mul_a      = {{(MUL_A_W-16){1'b0}}, filter_coef};
        mul_b      = t;
        state_next = ST_YSAT;
      end
      ST_YSAT: begin
        state_next = ST_SQ;
      end
      ST_SQ: begin
        mul_a      = {{(MUL_A_W-FILT_W){prev_filtered[FILT_W-1]}}, prev_filtered};
        mul_b      = {{(T_W-FILT_W){prev_filtered[FILT_W-1]}}, prev_filtered};
        state_next = ST_ACC;
      end
      ST_ACC: begin
        state_next = end_q ? ST_DIV : ST_IDLE;
      end
      ST_DIV: begin
        // empty window: mean is zero, go straight to the root
        if (sample_counter == '0) begin
          sqrt_start = 1'b1;
          state_next = ST_SQRT_WAIT;
        end else begin
          div_start  = 1'b1;
          state_next = ST_DIV_WAIT;
        end
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          sqrt_start = 1'b1;
          state_next = ST_SQRT_WAIT;
        end
      end
      ST_SQRT_WAIT: begin
        if (sqrt_done) begin
          state_next = ST_SCALE;
        end
      end
      ST_SCALE: begin
        mul_a      = {{(MUL_A_W-ROOT_W){1'b0}}, rms};
        mul_b      = {{(T_W-16){1'b0}}, scale};
        state_next = ST_CUR;
      end
      ST_CUR: begin
        state_next = ST_PMUL;
      end
      ST_PMUL: begin
        mul_a      = {{(MUL_A_W-16){1'b0}}, cur_reg};
        mul_b      = {{(T_W-VOLTS_W){1'b0}}, mains_volts};
        state_next = ST_PDIV;
      end
      ST_PDIV: begin
        mul_a      = POWER_RECIP;
        mul_b      = T_W'(pwr_num);
        state_next = ST_PDIV_WAIT;
      end
      ST_PDIV_WAIT: begin
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!result_valid || result_ready) begin
          result_load = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_coef    <= 16'd65274;
      scale          <= 16'd3094;
      threshold      <= 16'd150;
      mains_volts    <= VOLTS_W'(230);
      prev_sample    <= '0;
      prev_filtered  <= '0;
      square_sum     <= '0;
      sample_counter <= '0;
      result_valid   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_FILTER_COEF: filter_coef <= cfg_data;
          CFG_SCALE:       scale       <= cfg_data;
          CFG_THRESHOLD:   threshold   <= cfg_data;
          CFG_MAINS_VOLTS: mains_volts <= cfg_data[VOLTS_W-1:0];
          default: ;
        endcase
      end

      if (accept && sample.window_start) begin
        prev_sample    <= sample.adc_sample;
        prev_filtered  <= '0;
        square_sum     <= '0;
        sample_counter <= '0;
      end

      if (state == ST_YSAT) begin
        prev_filtered <= y_sat;
        prev_sample   <= x_q;
        if (sample_counter != 16'hFFFF) begin
          sample_counter <= sample_counter + 16'd1;
        end
      end

      if (state == ST_ACC) begin
        square_sum <= sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
      end

      if (result_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      x_q   <= sample.adc_sample;
      end_q <= sample.window_end;
    end
    if (state == ST_CUR) begin
      cut_reg <= (cur_val < threshold);
      cur_reg <= (cur_val < threshold) ? 16'd0 : cur_val;
    end
    if (state == ST_PDIV_WAIT) begin
      pwr_reg <= prod[POWER_SHIFT +: 16];
    end
    if (result_load) begin
      result.current_ma      <= cur_reg;
      result.power_w         <= pwr_reg;
      result.samples_used    <= sample_counter;
      result.below_threshold <= cut_reg;
    end
  end

  a_cut_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.below_threshold |-> result.current_ma == 16'd0)
    else $error("cut result carries nonzero current");

  a_power_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.power_w <= result.current_ma)
    else $error("power exceeds current bound");

  a_count_mono: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |=> sample_counter >= $past(sample_counter))
    else $error("sample count dropped during processing");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV_WAIT)
    else $error("divider finished outside its wait state");

  a_sqrt_done: assert property (@(posedge clk) disable iff (rst)
    sqrt_done |-> state == ST_SQRT_WAIT)
    else $error("root finished outside its wait state");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for ac_current_rms_meter: random and directed sample streams,
// register writes between windows, and a scoreboard that predicts each window reading.
// Depends on acrms_pkg and the ac_current_rms_meter RTL.
import acrms_pkg::*;

class meter_scoreboard;
  logic [15:0]        coef;
  logic [15:0]        scale;
  logic [15:0]        thresh;
  logic [8:0]         volts;
  logic [11:0]        last_x;
  logic signed [23:0] last_y;
  logic [63:0]        energy;
  logic [15:0]        count;
  result_t            readings_due[$];
  int                 errors;

  function new();
    coef    = 16'd65274;
    scale   = 16'd3094;
    thresh  = 16'd150;
    volts   = 9'd230;
    last_x  = '0;
    last_y  = '0;
    energy  = '0;
    count   = '0;
    errors  = 0;
  endfunction

  function void write_reg(cfg_reg_t idx, logic [15:0] data);
    case (idx)
      CFG_FILTER_COEF: coef = data;
      CFG_SCALE:       scale = data;
      CFG_THRESHOLD:   thresh = data;
      CFG_MAINS_VOLTS: volts = data[8:0];
      default: ;
    endcase
  endfunction

  function int due();
    return readings_due.size();
  endfunction

  function logic [31:0] int_sqrt(logic [63:0] v);
    logic [31:0] root;
    logic [31:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (32'd1 << b);
      if ({32'd0, trial} * {32'd0, trial} <= v) root = trial;
    end
    return root;
  endfunction

  // Advance the filter and window state for one accepted sample; queue a reading on window end.
  function void account_sample(sample_t s);
    longint      t;
    longint      y;
    logic [64:0] total;
    logic [63:0] mean;
    logic [31:0] root;
    logic [63:0] cur;
    logic [63:0] pwr;
    logic        cut;
    result_t     r;
    if (s.window_start) begin
      last_x = s.adc_sample;
      last_y = '0;
      energy = '0;
      count  = '0;
    end else begin
      t = longint'(last_y) + (longint'(s.adc_sample) - longint'(last_x)) * 256;
      y = (longint'(coef) * t + 32768) >>> 16;
      if (y > 8388607) y = 8388607;
      if (y < -8388608) y = -8388608;
      total  = {1'b0, energy} + {1'b0, 64'(y * y)};
      energy = total[64] ? '1 : total[63:0];
      if (count != 16'hFFFF) count = count + 16'd1;
      last_y = y[23:0];
      last_x = s.adc_sample;
    end
    if (!s.window_end) return;
    mean = (count == 0) ? 64'd0 : energy / {48'd0, count};
    root = int_sqrt(mean);
    cur  = ({32'd0, root} * {48'd0, scale} + 64'd32768) >> 16;
    if (cur > 64'd65535) cur = 64'd65535;
    cut = cur < {48'd0, thresh};
    if (cut) cur = '0;
    pwr = (cur * {55'd0, volts} + 64'd500) / 64'd1000;
    if (pwr > 64'd65535) pwr = 64'd65535;
    r.current_ma      = cur[15:0];
    r.power_w         = pwr[15:0];
    r.samples_used    = count;
    r.below_threshold = cut;
    readings_due.push_back(r);
  endfunction

  task report(string msg);
    errors++;
    $display("%0t mismatch: %s", $realtime, msg);
  endtask

  task check_result(result_t got);
    result_t want;
    if (readings_due.size() == 0) begin
      report($sformatf("unexpected reading cur=%0d pwr=%0d n=%0d cut=%0b",
                       got.current_ma, got.power_w, got.samples_used, got.below_threshold));
      return;
    end
    want = readings_due.pop_front();
    if (got.current_ma !== want.current_ma)
      report($sformatf("current_ma got %0d want %0d", got.current_ma, want.current_ma));
    if (got.power_w !== want.power_w)
      report($sformatf("power_w got %0d want %0d", got.power_w, want.power_w));
    if (got.samples_used !== want.samples_used)
      report($sformatf("samples_used got %0d want %0d", got.samples_used, want.samples_used));
    if (got.below_threshold !== want.below_threshold)
      report($sformatf("below_threshold got %0b want %0b",
                       got.below_threshold, want.below_threshold));
  endtask
endclass

module tb;
  localparam int STALL_LIMIT = 20000;  // cycles with no transfer on any channel
  localparam int SETTLE      = 300;    // longer than a window-end computation

  logic        clk = 1'b0;
  logic        rst;
  logic        sample_valid;
  logic        sample_ready;
  sample_t     sample;
  logic        result_valid;
  logic        result_ready;
  result_t     result;
  logic        cfg_valid;
  logic        cfg_ready;
  cfg_reg_t    cfg_index;
  logic [15:0] cfg_data;

  int tx_idle = 19;
  int rx_idle = 62;
  int stall_cycles = 0;

  meter_scoreboard sb = new();

  ac_current_rms_meter dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if ((sample_valid && sample_ready) || (result_valid && result_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("[ac_current_rms_meter] ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Result side: ready toggles at the falling edge, transfers are checked at the rising edge.
  initial begin
    result_ready = 1'b0;
    forever begin
      @(negedge clk);
      result_ready <= ($urandom_range(99) >= rx_idle);
      @(posedge clk);
      if (result_valid && result_ready) sb.check_result(result);
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic push_sample(input logic [11:0] x, input logic st, input logic en);
    sample_t s;
    s.adc_sample   = x;
    s.window_start = st;
    s.window_end   = en;
    while ($urandom_range(99) < tx_idle) begin
      sample_valid <= 1'b0;
      @(negedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= s;
    do @(posedge clk); while (!sample_ready);
    sb.account_sample(s);
    @(negedge clk);
  endtask

  // Sender holds off until every reading is out and the block has finished any sample.
  task automatic quiesce();
    sample_valid <= 1'b0;
    while (sb.due() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic program_meter(input logic [15:0] coef, input logic [15:0] scale,
                               input logic [15:0] thresh, input logic [8:0] volts);
    cfg_reg_t    regs[4];
    logic [15:0] vals[4];
    regs[0] = CFG_FILTER_COEF;
    regs[1] = CFG_SCALE;
    regs[2] = CFG_THRESHOLD;
    regs[3] = CFG_MAINS_VOLTS;
    vals[0] = coef;
    vals[1] = scale;
    vals[2] = thresh;
    vals[3] = {7'd0, volts};
    quiesce();
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      sb.write_reg(regs[i], vals[i]);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic program_random();
    logic [15:0] coef;
    logic [15:0] scale;
    logic [15:0] thresh;
    coef   = ($urandom_range(9) < 7) ? 16'($urandom_range(64000, 65535))
                                     : 16'($urandom_range(65535));
    scale  = $urandom_range(1) ? 16'($urandom_range(8000)) : 16'($urandom_range(65535));
    thresh = $urandom_range(1) ? 16'($urandom_range(1000)) : 16'($urandom_range(65535));
    program_meter(coef, scale, thresh, 9'($urandom_range(511)));
  endtask

  // Noisy waveform around a DC level, clamped to the converter range.
  function automatic logic [11:0] wave(int dc, int amp);
    int v;
    v = dc + int'($urandom_range(2 * amp)) - amp;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[11:0];
  endfunction

  // Mostly well-formed windows with random content, plus short bursts of random flags.
  task automatic random_segment(input int budget);
    int sent;
    int n;
    int dc;
    int amp;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(99) < 85) begin
        n   = ($urandom_range(19) == 0) ? $urandom_range(200) : $urandom_range(1, 24);
        dc  = $urandom_range(4095);
        amp = ($urandom_range(3) == 0) ? $urandom_range(8) : $urandom_range(2047);
        push_sample(wave(dc, amp), 1'b1, n == 0);
        for (int i = 1; i <= n; i++) push_sample(wave(dc, amp), 1'b0, i == n);
        sent += n + 1;
      end else begin
        n = $urandom_range(1, 6);
        repeat (n) push_sample(12'($urandom_range(4095)), $urandom_range(9) == 0,
                               $urandom_range(3) == 0);
        sent += n;
      end
    end
  endtask

  initial begin
    rst          = 1'b1;
    sample_valid = 1'b0;
    sample       = '0;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_FILTER_COEF;
    cfg_data     = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset configuration; samples before any start fall into the reset window.
    push_sample(12'd4095, 1'b0, 1'b0);
    push_sample(12'd0,    1'b0, 1'b1);
    push_sample(12'd0,    1'b0, 1'b0);   // window keeps growing after its end
    push_sample(12'd4095, 1'b0, 1'b1);
    push_sample(12'd2048, 1'b1, 1'b1);   // start and end together: empty window
    push_sample(12'd0,    1'b1, 1'b0);
    push_sample(12'd4095, 1'b0, 1'b0);
    push_sample(12'd0,    1'b0, 1'b0);
    push_sample(12'd4095, 1'b0, 1'b1);
    push_sample(12'd2048, 1'b1, 1'b0);   // tiny swing, cut by the noise threshold
    push_sample(12'd2049, 1'b0, 1'b0);
    push_sample(12'd2047, 1'b0, 1'b1);
    push_sample(12'd4095, 1'b1, 1'b0);
    push_sample(12'd4095, 1'b0, 1'b1);

    program_meter(16'hFFFF, 16'hFFFF, 16'd0, 9'd511);
    push_sample(12'd0,    1'b1, 1'b0);
    push_sample(12'd4095, 1'b0, 1'b0);
    push_sample(12'd0,    1'b0, 1'b1);
    push_sample(12'd1234, 1'b1, 1'b1);

    program_meter(16'd0, 16'd0, 16'hFFFF, 9'd0);
    push_sample(12'd100,  1'b1, 1'b0);
    push_sample(12'd4000, 1'b0, 1'b1);
    push_sample(12'd4000, 1'b1, 1'b1);

    repeat (3) begin
      program_random();
      random_segment(110);
    end

    tx_idle = 62;
    rx_idle = 19;
    repeat (3) begin
      program_random();
      random_segment(110);
    end

    tx_idle = 0;
    rx_idle = 0;
    repeat (3) begin
      program_random();
      random_segment(110);
    end

    // Back to the reset configuration; one short window read twice.
    program_meter(16'd65274, 16'd3094, 16'd150, 9'd230);
    push_sample(12'($urandom_range(4095)), 1'b1, 1'b0);
    push_sample(12'd0,    1'b0, 1'b1);
    push_sample(12'd4095, 1'b0, 1'b0);
    push_sample(12'd0,    1'b0, 1'b1);

    quiesce();
    if (sb.errors == 0 && sb.due() == 0) begin
      $display("[ac_current_rms_meter] OK");
    end else begin
      $display("[ac_current_rms_meter] ERROR");
    end
    $finish;
  end
endmodule
